>>> design/call_return_trace_monitor_defines.svh
// assertion macros for the call/return trace monitor checks
// used by the port checker; expects i_clk and i_rst_n in the using scope
`ifndef CALL_RETURN_TRACE_MONITOR_DEFINES_SVH
`define CALL_RETURN_TRACE_MONITOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CRTM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("crtm port check failed");

// next-cycle implication, disabled during reset
`define CRTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("crtm port check failed");

`endif

>>> design/crtm_pkg.sv
// shared types, codes and constants of the call/return trace monitor
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crtm_pkg;

    // fixed field widths
    localparam int WORD_W   = 64;
    localparam int INSTR_W  = 32;
    localparam int SLOT_W   = 7;
    localparam int COUNT_W  = 8;
    localparam int KIND_W   = 2;
    localparam int DEPTH_W  = 16;
    localparam int TCNT_W   = 16;

    // parameter defaults
    localparam int FUNC_SLOTS_DEF = 128;
    localparam int TAIL_SLOTS_DEF = 32;
    localparam int ADDR_WIDTH_DEF = 64;

    // instruction encodings of interest
    localparam logic [INSTR_W-1:0] RET_WORD       = 32'h0000_8067;
    localparam logic [INSTR_W-1:0] TAIL_JUMP_WORD = 32'h0007_8067;

    // action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TRACE = 1'b1;

    // event codes
    localparam logic [KIND_W-1:0] EV_NONE = 2'd0;
    localparam logic [KIND_W-1:0] EV_CALL = 2'd1;
    localparam logic [KIND_W-1:0] EV_RET  = 2'd2;

    typedef logic [SLOT_W-1:0] t_slot;

    // first-hit record handed from cell to cell
    typedef struct packed {
        logic  ret_hit;
        t_slot ret_slot;
        logic  call_hit;
        t_slot call_slot;
    } t_link;

    // table write broadcast to the cells
    typedef struct packed {
        logic  en;
        t_slot idx;
    } t_load;

    // command to the tail-call counter stack
    typedef struct packed {
        logic ret_step;
        logic push;
    } t_tail_cmd;

endpackage

`default_nettype wire

>>> design/crtm_if.sv
// valid/ready channel interfaces for trace input words and event output words
// depends on crtm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface crtm_in_if;
    logic                             valid;
    logic                             ready;
    logic                             action;
    logic [crtm_pkg::SLOT_W-1:0]      entry_index;
    logic [crtm_pkg::WORD_W-1:0]      func_start;
    logic [crtm_pkg::WORD_W-1:0]      func_end;
    logic [crtm_pkg::INSTR_W-1:0]     instr_word;
    logic [crtm_pkg::WORD_W-1:0]      cur_pc;
    logic [crtm_pkg::WORD_W-1:0]      next_pc;

    modport source (
        output valid, action, entry_index, func_start, func_end, instr_word, cur_pc, next_pc,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, func_start, func_end, instr_word, cur_pc, next_pc,
        output ready
    );
endinterface

interface crtm_out_if;
    logic                              valid;
    logic                              ready;
    logic [crtm_pkg::KIND_W-1:0]       event_kind;
    logic [crtm_pkg::SLOT_W-1:0]       func_slot;
    logic signed [crtm_pkg::DEPTH_W-1:0] report_depth;

    modport source (
        output valid, event_kind, func_slot, report_depth,
        input  ready
    );
    modport sink (
        input  valid, event_kind, func_slot, report_depth,
        output ready
    );
endinterface

`default_nettype wire

>>> design/crtm_cell.sv
// one range-table cell: holds a function's start/end and forwards the first hit
// depends on crtm_pkg
`timescale 1ns / 1ps
`default_nettype none

module crtm_cell #(
    parameter int INDEX      = 0,
    parameter int ADDR_WIDTH = crtm_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire crtm_pkg::t_load               i_load,
    input  wire logic [ADDR_WIDTH-1:0]         i_start,
    input  wire logic [ADDR_WIDTH-1:0]         i_end,
    input  wire logic [ADDR_WIDTH-1:0]         i_pc,
    input  wire logic [ADDR_WIDTH-1:0]         i_npc,
    input  wire logic                          i_is_ret,
    input  wire logic [crtm_pkg::COUNT_W-1:0]  i_func_count,
    input  wire crtm_pkg::t_link               i_link,
    output      crtm_pkg::t_link               o_link
);
    import crtm_pkg::*;

    logic [ADDR_WIDTH-1:0] r_start;
    logic [ADDR_WIDTH-1:0] r_end;
    t_link                 r_link;
    t_link                 n_link;
    logic                  w_active;
    logic                  w_ret_ok;
    logic                  w_call_ok;

    // entry storage, written by a load word aimed at this slot
    always_ff @(posedge i_clk) begin
        if (i_load.en && (int'(i_load.idx) == INDEX)) begin
            r_start <= i_start;
            r_end   <= i_end;
        end
    end

    // local range and start compares, only inside the searched part of the table
    always_comb begin
        w_active  = INDEX < int'(i_func_count);
        w_ret_ok  = w_active && i_is_ret && (i_pc > r_start) && (i_pc <= r_end) &&
                    ((i_npc < r_start) || (i_npc > r_end));
        w_call_ok = w_active && (i_npc == r_start);
    end

    // keep an earlier hit, otherwise claim this slot
    always_comb begin
        n_link = i_link;
        if (!i_link.ret_hit && w_ret_ok) begin
            n_link.ret_hit  = 1'b1;
            n_link.ret_slot = SLOT_W'(INDEX);
        end
        if (!i_link.call_hit && w_call_ok) begin
            n_link.call_hit  = 1'b1;
            n_link.call_slot = SLOT_W'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

>>> design/crtm_tail.sv
// tail-call counter stack: level pointer plus saturating counters
// depends on crtm_pkg
`timescale 1ns / 1ps
`default_nettype none

module crtm_tail #(
    parameter int TAIL_SLOTS = crtm_pkg::TAIL_SLOTS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire crtm_pkg::t_tail_cmd i_cmd,
    output      logic                o_extra_dec
);
    import crtm_pkg::*;

    localparam int LVL_W = (TAIL_SLOTS > 1) ? $clog2(TAIL_SLOTS) : 1;

    logic [TCNT_W-1:0] r_cnt [TAIL_SLOTS];
    logic [LVL_W-1:0]  r_lvl;
    logic [LVL_W-1:0]  n_lvl;
    logic [TCNT_W-1:0] w_cur;
    logic              w_at_top;
    logic              w_wr;
    logic [LVL_W-1:0]  w_wr_idx;
    logic [TCNT_W-1:0] w_wr_data;

    // slots above the level always hold zero, so only the current one is read
    assign w_cur    = r_cnt[r_lvl];
    assign w_at_top = (r_lvl == LVL_W'(TAIL_SLOTS - 1));

    // a return that empties the current counter costs one more depth step
    assign o_extra_dec = i_cmd.ret_step && (w_cur == TCNT_W'(1));

    // next level and the single counter write
    always_comb begin
        n_lvl     = r_lvl;
        w_wr      = 1'b0;
        w_wr_idx  = r_lvl;
        w_wr_data = w_cur;
        if (i_cmd.ret_step) begin
            if (w_cur != '0) begin
                w_wr      = 1'b1;
                w_wr_data = w_cur - TCNT_W'(1);
                if ((w_cur == TCNT_W'(1)) && (r_lvl != '0)) begin
                    n_lvl = r_lvl - LVL_W'(1);
                end
            end
        end else if (i_cmd.push) begin
            if ((w_cur != '0) && !w_at_top) begin
                n_lvl     = r_lvl + LVL_W'(1);
                w_wr      = 1'b1;
                w_wr_idx  = r_lvl + LVL_W'(1);
                w_wr_data = TCNT_W'(1);
            end else if (w_cur != '1) begin
                w_wr      = 1'b1;
                w_wr_data = w_cur + TCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl <= '0;
            for (int k = 0; k < TAIL_SLOTS; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            r_lvl <= n_lvl;
            if (w_wr) begin
                r_cnt[w_wr_idx] <= w_wr_data;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/call_return_trace_monitor.sv
// Call/return trace monitor. A load word writes one function's start and end address into
// the range table and gives an event-none word. A trace word is broadcast to a row of
// FUNC_SLOTS table cells; the first matching slot for a return and for a call ripples down
// the row one cell per clock, and the event word is formed once the hit record has reached
// the end of the row. One word is in work at a time; the result register lets the next
// word in while the last event still waits on the output.
// func_count must be written only while the block is idle (a rule for the user, unchecked).
// depends on crtm_pkg, crtm_if, crtm_cell, crtm_tail
`timescale 1ns / 1ps
`default_nettype none

module call_return_trace_monitor #(
    parameter int FUNC_SLOTS = crtm_pkg::FUNC_SLOTS_DEF,
    parameter int TAIL_SLOTS = crtm_pkg::TAIL_SLOTS_DEF,
    parameter int ADDR_WIDTH = crtm_pkg::ADDR_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [crtm_pkg::COUNT_W-1:0] i_cfg_wdata,
    crtm_in_if.sink                           i_in,
    crtm_out_if.source                        o_out
);
    import crtm_pkg::*;

    localparam int   CNT_W    = $clog2(FUNC_SLOTS + 1);
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_BUSY  = 1'b1;

    // control
    logic                  r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [COUNT_W-1:0]    r_func_count;
    logic [DEPTH_W-1:0]    r_depth;
    logic [DEPTH_W-1:0]    n_depth;

    // accepted word
    logic                  r_action;
    t_slot                 r_idx;
    logic [ADDR_WIDTH-1:0] r_start;
    logic [ADDR_WIDTH-1:0] r_end;
    logic [ADDR_WIDTH-1:0] r_pc;
    logic [ADDR_WIDTH-1:0] r_npc;
    logic                  r_is_ret;
    logic                  r_is_tail;

    // result register
    logic                  r_out_valid;
    logic [KIND_W-1:0]     r_kind;
    t_slot                 r_slot;
    logic [DEPTH_W-1:0]    r_shown;
    logic [KIND_W-1:0]     n_kind;
    t_slot                 n_slot;
    logic [DEPTH_W-1:0]    n_shown;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_done;
    logic                  w_commit;
    logic                  w_extra_dec;
    t_load                 w_load;
    t_tail_cmd             w_tail_cmd;
    t_link                 w_link [FUNC_SLOTS+1];

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_done     = (r_action == ACT_LOAD) || (r_cnt == CNT_W'(FUNC_SLOTS));
    assign w_commit   = (r_state == ST_BUSY) && w_done && w_out_free;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_count <= '0;
        end else if (i_cfg_we) begin
            r_func_count <= i_cfg_wdata;
        end
    end

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= i_in.action;
            r_idx     <= i_in.entry_index;
            r_start   <= i_in.func_start[ADDR_WIDTH-1:0];
            r_end     <= i_in.func_end[ADDR_WIDTH-1:0];
            r_pc      <= i_in.cur_pc[ADDR_WIDTH-1:0];
            r_npc     <= i_in.next_pc[ADDR_WIDTH-1:0];
            r_is_ret  <= (i_in.instr_word == RET_WORD);
            r_is_tail <= (i_in.instr_word == TAIL_JUMP_WORD);
        end
    end

    // sequencer: wait for the hit record to reach the end of the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_BUSY;
                        r_cnt   <= '0;
                    end
                end
                ST_BUSY: begin
                    if (w_commit) begin
                        r_state <= ST_IDLE;
                    end else if (r_cnt != CNT_W'(FUNC_SLOTS)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // row of table cells
    assign w_load.en  = w_commit && (r_action == ACT_LOAD);
    assign w_load.idx = r_idx;
    assign w_link[0]  = '0;

    for (genvar g = 0; g < FUNC_SLOTS; g++) begin : g_cell
        crtm_cell #(
            .INDEX      (g),
            .ADDR_WIDTH (ADDR_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_load       (w_load),
            .i_start      (r_start),
            .i_end        (r_end),
            .i_pc         (r_pc),
            .i_npc        (r_npc),
            .i_is_ret     (r_is_ret),
            .i_func_count (r_func_count),
            .i_link       (w_link[g]),
            .o_link       (w_link[g+1])
        );
    end

    // resolve the event and the depth update
    always_comb begin
        n_kind           = EV_NONE;
        n_slot           = '0;
        n_shown          = '0;
        n_depth          = r_depth;
        w_tail_cmd       = '0;
        if (r_action == ACT_TRACE) begin
            if (w_link[FUNC_SLOTS].ret_hit) begin
                n_kind              = EV_RET;
                n_slot              = w_link[FUNC_SLOTS].ret_slot;
                n_shown             = r_depth - DEPTH_W'(1);
                n_depth             = n_shown - DEPTH_W'(w_extra_dec);
                w_tail_cmd.ret_step = w_commit;
            end else if (w_link[FUNC_SLOTS].call_hit) begin
                n_kind          = EV_CALL;
                n_slot          = w_link[FUNC_SLOTS].call_slot;
                n_shown         = r_depth;
                n_depth         = r_depth + DEPTH_W'(1);
                w_tail_cmd.push = w_commit && r_is_tail;
            end
        end
    end

    crtm_tail #(
        .TAIL_SLOTS (TAIL_SLOTS)
    ) u_tail (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_tail_cmd),
        .o_extra_dec (w_extra_dec)
    );

    // call depth, wraps both ways
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (w_commit) begin
            r_depth <= n_depth;
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_kind  <= n_kind;
            r_slot  <= n_slot;
            r_shown <= n_shown;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_kind;
    assign o_out.func_slot    = r_slot;
    assign o_out.report_depth = r_shown;

endmodule

`default_nettype wire

>>> design/crtm_check.sv
// port-level checks of the call/return trace monitor, bound to the top level
// depends on crtm_pkg and call_return_trace_monitor_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "call_return_trace_monitor_defines.svh"

module crtm_check (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_in_valid,
    input wire logic                                i_in_ready,
    input wire logic                                i_out_valid,
    input wire logic                                i_out_ready,
    input wire logic [crtm_pkg::KIND_W-1:0]         i_event_kind,
    input wire logic [crtm_pkg::SLOT_W-1:0]         i_func_slot,
    input wire logic signed [crtm_pkg::DEPTH_W-1:0] i_report_depth
);
    import crtm_pkg::*;

    // a stalled event word stays offered
    `CRTM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // only defined event codes leave the block
    `CRTM_ASSERT_NOW(a_kind_legal, i_out_valid,
        (i_event_kind == EV_NONE) || (i_event_kind == EV_CALL) || (i_event_kind == EV_RET))

    // an event-none word carries zero slot and zero depth
    `CRTM_ASSERT_NOW(a_none_clean, i_out_valid && (i_event_kind == EV_NONE),
        (i_func_slot == '0) && (i_report_depth == '0))

    // one word in work at a time: no accept right after an accept
    `CRTM_ASSERT_NEXT(a_one_in_work, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind call_return_trace_monitor crtm_check u_crtm_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_event_kind   (o_out.event_kind),
    .i_func_slot    (o_out.func_slot),
    .i_report_depth (o_out.report_depth)
);

`default_nettype wire

>>> tb/sv/crtm_event_checker.sv
`timescale 1ns / 1ps
// call/return event checker: follows the input and output channels of the trace monitor
// depends on crtm_pkg and crtm_if; keeps its own range table, call depth and tail counters
module crtm_event_checker #(
    parameter int FUNC_SLOTS = crtm_pkg::FUNC_SLOTS_DEF,
    parameter int TAIL_SLOTS = crtm_pkg::TAIL_SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [crtm_pkg::COUNT_W-1:0] i_cfg_wdata,
    crtm_in_if                                in_ch,
    crtm_out_if                               out_ch,
    output int                                o_pending,
    output int                                o_fail_count
);
    import crtm_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        t_slot                     slot;
        logic signed [DEPTH_W-1:0] depth;
    } t_trace_event;

    // predicted monitor state
    logic [WORD_W-1:0]  range_start [FUNC_SLOTS];
    logic [WORD_W-1:0]  range_end   [FUNC_SLOTS];
    logic [DEPTH_W-1:0] depth_ctr;
    int unsigned        tail_lvl;
    logic [TCNT_W-1:0]  tail_cnt    [TAIL_SLOTS];
    int unsigned        searched;
    t_trace_event       expected_events [$];
    int                 fails = 0;
    int                 pending_words = 0;

    assign o_pending    = pending_words;
    assign o_fail_count = fails;

    task automatic report_mismatch(input string what);
        fails++;
        if (fails <= 40)
            $display("%0t ns: event mismatch: %s", $time, what);
    endtask

    // event word caused by one input word; updates the predicted state
    function automatic t_trace_event predict_event(
        input logic act, input t_slot idx, input logic [WORD_W-1:0] fs,
        input logic [WORD_W-1:0] fe, input logic [INSTR_W-1:0] word,
        input logic [WORD_W-1:0] pc, input logic [WORD_W-1:0] npc);
        t_trace_event ev;
        int unsigned  lim;
        int           i;
        bit           done;
        ev.kind  = EV_NONE;
        ev.slot  = '0;
        ev.depth = '0;
        lim  = (searched < FUNC_SLOTS) ? searched : FUNC_SLOTS;
        done = 1'b0;
        if (act == ACT_LOAD) begin
            if (idx < FUNC_SLOTS) begin
                range_start[idx] = fs;
                range_end[idx]   = fe;
            end
            return ev;
        end
        // return out of a function: pc in (start, end], next pc outside [start, end]
        if (word == RET_WORD) begin
            for (i = 0; i < lim && !done; i++) begin
                if (pc > range_start[i] && pc <= range_end[i] &&
                    (npc < range_start[i] || npc > range_end[i])) begin
                    depth_ctr = depth_ctr - 1'b1;
                    ev.kind   = EV_RET;
                    ev.slot   = t_slot'(i);
                    ev.depth  = depth_ctr;
                    // count down the current tail counter, with an extra depth step when it empties
                    if (tail_cnt[tail_lvl] != 0) begin
                        tail_cnt[tail_lvl] = tail_cnt[tail_lvl] - 1'b1;
                        if (tail_cnt[tail_lvl] == 0) begin
                            depth_ctr = depth_ctr - 1'b1;
                            if (tail_lvl != 0)
                                tail_lvl--;
                        end
                    end
                    done = 1'b1;
                end
            end
        end
        // call: first searched entry starting at next pc
        for (i = 0; i < lim && !done; i++) begin
            if (npc == range_start[i]) begin
                ev.kind  = EV_CALL;
                ev.slot  = t_slot'(i);
                ev.depth = depth_ctr;
                if (word == TAIL_JUMP_WORD) begin
                    if (tail_cnt[tail_lvl] != 0 && tail_lvl + 1 < TAIL_SLOTS)
                        tail_lvl++;
                    if (tail_cnt[tail_lvl] != '1)
                        tail_cnt[tail_lvl] = tail_cnt[tail_lvl] + 1'b1;
                end
                depth_ctr = depth_ctr + 1'b1;
                done = 1'b1;
            end
        end
        return ev;
    endfunction

    // follow both channels and the register port
    always @(posedge i_clk) begin
        t_trace_event want;
        if (!i_rst_n) begin
            for (int k = 0; k < FUNC_SLOTS; k++) begin
                range_start[k] = '0;
                range_end[k]   = '0;
            end
            for (int k = 0; k < TAIL_SLOTS; k++)
                tail_cnt[k] = '0;
            depth_ctr = '0;
            tail_lvl  = 0;
            searched  = 0;
            expected_events.delete();
        end else begin
            if (i_cfg_we)
                searched = i_cfg_wdata;
            if (in_ch.valid && in_ch.ready)
                expected_events.push_back(predict_event(in_ch.action, in_ch.entry_index,
                    in_ch.func_start, in_ch.func_end, in_ch.instr_word, in_ch.cur_pc,
                    in_ch.next_pc));
            if (out_ch.valid && out_ch.ready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch("event word with nothing expected");
                end else begin
                    want = expected_events.pop_front();
                    if (out_ch.event_kind !== want.kind)
                        report_mismatch($sformatf("event_kind %0d, expected %0d",
                            out_ch.event_kind, want.kind));
                    if (out_ch.func_slot !== want.slot)
                        report_mismatch($sformatf("func_slot %0d, expected %0d",
                            out_ch.func_slot, want.slot));
                    if (out_ch.report_depth !== want.depth)
                        report_mismatch($sformatf("report_depth %0d, expected %0d",
                            out_ch.report_depth, want.depth));
                end
            end
        end
        pending_words = expected_events.size();
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// top of the trace monitor bench: clock, reset, table loads, call/return traffic and verdict
// depends on crtm_pkg, crtm_if, crtm_event_checker and call_return_trace_monitor
module tb_top;
    import crtm_pkg::*;

    localparam int FUNC_SLOTS    = FUNC_SLOTS_DEF;
    localparam int TAIL_SLOTS    = TAIL_SLOTS_DEF;
    localparam int SETTLE_CYCLES = FUNC_SLOTS + 8;
    localparam int TOTAL_WORDS   = 1400;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_wdata;
    int                 fail_count;
    int                 pending_words;

    // stimulus-side view of the loaded table
    logic [WORD_W-1:0] start_copy [FUNC_SLOTS];
    logic [WORD_W-1:0] end_copy   [FUNC_SLOTS];
    int unsigned       active_count;
    int                open_calls [$];
    int                words_sent;
    bit                tx_steady;
    bit                rx_steady;

    crtm_in_if  in_ch ();
    crtm_out_if out_ch ();

    call_return_trace_monitor #(
        .FUNC_SLOTS(FUNC_SLOTS),
        .TAIL_SLOTS(TAIL_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    crtm_event_checker #(
        .FUNC_SLOTS(FUNC_SLOTS),
        .TAIL_SLOTS(TAIL_SLOTS)
    ) event_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .o_pending   (pending_words),
        .o_fail_count(fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far above the slowest legal run
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [INSTR_W-1:0] plain_word();
        logic [INSTR_W-1:0] w;
        do
            w = $urandom;
        while (w == RET_WORD || w == TAIL_JUMP_WORD);
        return w;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // pc strictly inside (start, end]; only called where end > start
    function automatic logic [WORD_W-1:0] inner_pc(input int k);
        logic [WORD_W-1:0] span;
        span = end_copy[k] - start_copy[k];
        return start_copy[k] + 1 + (rand_addr() % span);
    endfunction

    // next pc outside [start, end]
    function automatic logic [WORD_W-1:0] outer_pc(input int k);
        logic [WORD_W-1:0] a;
        case ($urandom_range(0, 2))
            0: a = end_copy[k] + 4 * $urandom_range(1, 16);
            1: a = start_copy[k] - 4 * $urandom_range(1, 16);
            default: a = rand_addr();
        endcase
        if (a >= start_copy[k] && a <= end_copy[k])
            a = end_copy[k] + 1;
        return a;
    endfunction

    function automatic int pick_slot();
        int lim;
        lim = (active_count == 0) ? FUNC_SLOTS :
              (active_count < FUNC_SLOTS) ? active_count : FUNC_SLOTS;
        return $urandom_range(0, lim - 1);
    endfunction

    // one word on the input channel, then an optional gap
    task automatic drive_word(input logic act, input t_slot idx, input logic [WORD_W-1:0] fs,
        input logic [WORD_W-1:0] fe, input logic [INSTR_W-1:0] word,
        input logic [WORD_W-1:0] pc, input logic [WORD_W-1:0] npc);
        int gap;
        in_ch.valid       <= 1'b1;
        in_ch.action      <= act;
        in_ch.entry_index <= idx;
        in_ch.func_start  <= fs;
        in_ch.func_end    <= fe;
        in_ch.instr_word  <= word;
        in_ch.cur_pc      <= pc;
        in_ch.next_pc     <= npc;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        words_sent++;
        gap = (tx_steady || $urandom_range(0, 99) < 60) ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic trace_word(input logic [INSTR_W-1:0] word, input logic [WORD_W-1:0] pc,
        input logic [WORD_W-1:0] npc);
        drive_word(ACT_TRACE, t_slot'($urandom), rand_addr(), rand_addr(), word, pc, npc);
    endtask

    task automatic load_entry(input int k, input logic [WORD_W-1:0] s,
        input logic [WORD_W-1:0] e);
        start_copy[k] = s;
        end_copy[k]   = e;
        drive_word(ACT_LOAD, t_slot'(k), s, e, $urandom, rand_addr(), rand_addr());
    endtask

    // hold input until every event word is back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_words != 0);
    endtask

    task automatic set_func_count(input int unsigned v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= COUNT_W'(v);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        active_count = v;
    endtask

    // return from the innermost open call, or from any function
    task automatic return_word();
        int k;
        k = (open_calls.size() != 0) ? open_calls.pop_back() : pick_slot();
        if (end_copy[k] > start_copy[k])
            trace_word(RET_WORD, inner_pc(k), outer_pc(k));
        else
            trace_word(RET_WORD, rand_addr(), rand_addr());
    endtask

    task automatic call_word(input logic [INSTR_W-1:0] word);
        int k;
        k = pick_slot();
        if (open_calls.size() < 64)
            open_calls.push_back(k);
        trace_word(word, rand_addr(), start_copy[k]);
    endtask

    // one random step of call/return traffic, loads and noise
    task automatic random_step();
        int r;
        int n;
        logic [WORD_W-1:0] s;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            call_word(($urandom_range(0, 3) == 0) ? TAIL_JUMP_WORD : plain_word());
        end else if (r < 65) begin
            return_word();
        end else if (r < 71) begin
            // run of tail jumps deep enough to fill the counter stack
            n = $urandom_range(1, 40);
            repeat (n) call_word(TAIL_JUMP_WORD);
        end else if (r < 81) begin
            s = rand_addr();
            if ($urandom_range(0, 1) == 0)
                load_entry($urandom_range(0, FUNC_SLOTS - 1), s,
                           s + 4 * $urandom_range(1, 63));
            else
                load_entry($urandom_range(0, FUNC_SLOTS - 1), s, rand_addr());
        end else begin
            case ($urandom_range(0, 2))
                0: trace_word(RET_WORD, rand_addr(), rand_addr());
                1: trace_word(TAIL_JUMP_WORD, rand_addr(), rand_addr());
                default: trace_word($urandom, rand_addr(), rand_addr());
            endcase
        end
    endtask

    // result side stalls
    initial begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0)
                    hold = gap_len();
            end
        end
    end

    // stimulus
    initial begin
        logic [WORD_W-1:0] base;
        int unsigned       counts [8];
        int                seg;
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_LOAD;
        in_ch.entry_index = '0;
        in_ch.func_start  = '0;
        in_ch.func_end    = '0;
        in_ch.instr_word  = '0;
        in_ch.cur_pc      = '0;
        in_ch.next_pc     = '0;
        active_count      = 0;
        words_sent        = 0;
        tx_steady         = 1'b0;
        rx_steady         = 1'b0;
        counts = '{255, 1, 0, 128, 2, 200, 64, 128};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing searched right after reset
        trace_word(RET_WORD, rand_addr(), rand_addr());
        trace_word(TAIL_JUMP_WORD, rand_addr(), rand_addr());

        // fill the whole table with small functions in a row
        base = {16'h0, $urandom, 16'h0};
        for (int k = 0; k < FUNC_SLOTS; k++)
            load_entry(k, base + k * 256, base + k * 256 + 4 * $urandom_range(1, 63));
        // duplicate start, empty range, inverted range, overlap, top and bottom of memory
        load_entry(11, start_copy[10], start_copy[10] + 64'h80);
        load_entry(20, start_copy[20], start_copy[20]);
        load_entry(21, start_copy[21], start_copy[21] - 4);
        load_entry(30, start_copy[30], start_copy[31] + 64'h20);
        load_entry(126, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF);
        load_entry(127, 64'h0, 64'h100);
        set_func_count(FUNC_SLOTS);

        // directed traffic
        trace_word(RET_WORD, inner_pc(5), outer_pc(5));         // return at depth zero
        trace_word(plain_word(), rand_addr(), start_copy[5]);
        trace_word(32'hFFFF_FFFF, rand_addr(), 64'h0);          // call to address zero
        trace_word(32'h0, rand_addr(), start_copy[126]);
        trace_word(RET_WORD, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);   // pc at top of memory
        trace_word(RET_WORD, end_copy[7], outer_pc(7));         // pc on the end address
        trace_word(RET_WORD, start_copy[8], start_copy[9]);     // pc on start: a call instead
        trace_word(RET_WORD, inner_pc(8), start_copy[8]);       // next pc on own start
        trace_word(RET_WORD, inner_pc(8), end_copy[8]);         // next pc on own end
        trace_word(RET_WORD, rand_addr(), rand_addr());         // return with no match
        trace_word(plain_word(), rand_addr(), start_copy[11]);  // first of two equal starts
        trace_word(RET_WORD, start_copy[20], outer_pc(20));     // empty range
        repeat (3) trace_word(TAIL_JUMP_WORD, rand_addr(), start_copy[3]);
        repeat (3) trace_word(RET_WORD, inner_pc(3), outer_pc(3));
        trace_word(TAIL_JUMP_WORD, rand_addr(), rand_addr());   // tail jump with no match

        // random segments, each under its own search count
        seg = 0;
        while (words_sent < TOTAL_WORDS) begin
            set_func_count(seg < 8 ? counts[seg] : $urandom_range(1, FUNC_SLOTS));
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(60, 140)) random_step();
            seg++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/crtm_pkg.sv
design/crtm_if.sv
design/crtm_cell.sv
design/crtm_tail.sv
design/call_return_trace_monitor.sv
design/crtm_check.sv
tb/sv/crtm_event_checker.sv
tb/sv/tb_top.sv
